// File: hdl/gpp_pkg.sv
// ----------------------------------------------------------------------------
// gpp_pkg: shared types and constants for the fp16 panel packer
// widths and configuration register indexes
// ----------------------------------------------------------------------------
package gpp_pkg;

   localparam int MaxDim    = 4096;
   localparam int CfgWidth  = 13;
   localparam int IdxWidth  = 12;
   localparam int DestWidth = 24;

   typedef enum logic [0:0] {
      CSR_ROW_COUNT = 1'b0,
      CSR_COL_COUNT = 1'b1
   } csr_index_type;

endpackage

// File: hdl/gpp_half_conv.sv
// ----------------------------------------------------------------------------
// gpp_half_conv: binary32 to binary16 conversion, three register stages
// round to nearest even, overflow to infinity, subnormals kept, nan quieted
// ----------------------------------------------------------------------------
module gpp_half_conv (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] value_bits,
   output logic [15:0] half_bits
);
   import gpp_pkg::*;

   // operand classes
   typedef enum logic [1:0] {
      KIND_NORMAL  = 2'd0,
      KIND_SPECIAL = 2'd1,
      KIND_SUBNORM = 2'd2,
      KIND_ZERO    = 2'd3
   } kind_type;

   // stage 1: classify and pick the shift amount
   logic        sign_ff;
   logic [4:0]  exp_ff;
   logic [22:0] man_ff;
   kind_type    kind_ff;
   logic [15:0] spec_ff;
   logic [4:0]  shift_ff;

   kind_type    kind_in;
   logic [15:0] spec_in;
   logic [7:0]  e_w;
   logic [22:0] m_w;
   logic [7:0]  s_w;

   assign e_w = value_bits[30:23];
   assign m_w = value_bits[22:0];
   assign s_w = 8'd126 - e_w;

   always_comb begin
      kind_in = KIND_NORMAL;
      spec_in = 16'h0000;
      if (e_w == 8'hFF) begin
         kind_in = KIND_SPECIAL;
         spec_in = (m_w != 23'd0) ? {1'b0, 5'h1F, 1'b1, m_w[21:13]} : 16'h7C00;
      end else if (e_w >= 8'd143) begin
         kind_in = KIND_SPECIAL;
         spec_in = 16'h7C00;
      end else if (e_w >= 8'd113) begin
         kind_in = KIND_NORMAL;
      end else if (e_w < 8'd102) begin
         kind_in = KIND_ZERO;
      end else begin
         kind_in = KIND_SUBNORM;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sign_ff  <= value_bits[31];
         exp_ff   <= e_w[4:0];
         man_ff   <= m_w;
         kind_ff  <= kind_in;
         spec_ff  <= spec_in;
         shift_ff <= s_w[4:0];
      end
   end

   // stage 2: align mantissa, compute round decision
   logic        sign2_ff;
   logic [14:0] base2_ff;
   logic        rnd2_ff;

   logic [23:0] f_w;
   logic [23:0] q_w;
   logic [23:0] r_w;
   logic [23:0] half_w;
   logic [14:0] base_in;
   logic        rnd_in;
   logic [12:0] rem_w;

   assign f_w    = {1'b1, man_ff};
   assign q_w    = f_w >> shift_ff;
   assign half_w = 24'd1 << (shift_ff - 5'd1);
   assign r_w    = f_w & ((24'd1 << shift_ff) - 24'd1);
   assign rem_w  = man_ff[12:0];

   always_comb begin
      base_in = 15'd0;
      rnd_in  = 1'b0;
      case (kind_ff)
         KIND_NORMAL: begin
            base_in = {exp_ff + 5'd16, man_ff[22:13]};
            rnd_in  = (rem_w > 13'h1000) || (rem_w == 13'h1000 && man_ff[13]);
         end
         KIND_SPECIAL: base_in = spec_ff[14:0];
         KIND_SUBNORM: begin
            base_in = q_w[14:0];
            rnd_in  = (r_w > half_w) || (r_w == half_w && q_w[0]);
         end
         default: base_in = 15'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sign2_ff <= sign_ff;
         base2_ff <= base_in;
         rnd2_ff  <= rnd_in;
      end
   end

   // stage 3: apply rounding increment
   logic [15:0] half_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         half_ff <= {sign2_ff, base2_ff + {14'd0, rnd2_ff}};
      end
   end

   assign half_bits = half_ff;

endmodule

// File: hdl/gemm_panel_pack_fp16_top.sv
// ----------------------------------------------------------------------------
// gemm_panel_pack_fp16_top: fp32 to fp16 a-matrix panel packer
// rsp_valid follows start through the valid pipe; throughput: one beat per cycle
// busy is never high, so a start is taken every cycle
// reset clears the valid pipe and returns row_count and col_count to 4
// the receiver cannot stall: each rsp beat shows for exactly one cycle
// ----------------------------------------------------------------------------
module gemm_panel_pack_fp16_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [31:0]                    req_value_bits,
   input  logic [gpp_pkg::IdxWidth-1:0]   req_row_index,
   input  logic [gpp_pkg::IdxWidth-1:0]   req_col_index,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_index,
   input  logic [gpp_pkg::CfgWidth-1:0]   csr_data,
   output logic                           rsp_valid,
   output logic [gpp_pkg::DestWidth-1:0]  rsp_dest_index,
   output logic [15:0]                    rsp_half_bits,
   output logic                           rsp_out_of_range
);
   import gpp_pkg::*;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // configuration registers, saturated to the max dimension on write
   logic [CfgWidth-1:0] rows_ff, cols_ff;
   logic [CfgWidth-1:0] sat_in;

   assign sat_in = (csr_data > CfgWidth'(MaxDim)) ? CfgWidth'(MaxDim) : csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= CfgWidth'(4);
         cols_ff <= CfgWidth'(4);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_ROW_COUNT) rows_ff <= sat_in;
         else                            cols_ff <= sat_in;
      end
   end

   // valid pipe
   logic [2:0] vld_ff;
   logic       acc;
   assign acc = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 3'b000;
      else       vld_ff <= {vld_ff[1:0], acc};
   end

   gpp_half_conv u_conv (
      .clock      (clock),
      .en         (1'b1),
      .value_bits (req_value_bits),
      .half_bits  (rsp_half_bits)
   );

   // stage 1: range check, panel base row and height
   logic                oor1_ff;
   logic [IdxWidth-1:0] p1_ff, c1_ff;
   logic [1:0]          hs1_ff;   // height as shift: 0,1,2
   logic [1:0]          off1_ff;
   logic [CfgWidth-1:0] cols1_ff;

   logic [CfgWidth-1:0] full_w;
   logic [IdxWidth-1:0] p_in;
   logic [1:0]          hs_in;
   logic                oor_in;

   assign full_w = {rows_ff[CfgWidth-1:2], 2'b00};
   assign oor_in = ({1'b0, req_row_index} >= rows_ff) || ({1'b0, req_col_index} >= cols_ff);

   always_comb begin
      if ({1'b0, req_row_index} < full_w) begin
         p_in  = {req_row_index[IdxWidth-1:2], 2'b00};
         hs_in = 2'd2;
      end else if (rows_ff[1] && ({1'b0, req_row_index} < full_w + CfgWidth'(2))) begin
         p_in  = full_w[IdxWidth-1:0];
         hs_in = 2'd1;
      end else begin
         p_in  = req_row_index;
         hs_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      oor1_ff  <= oor_in;
      p1_ff    <= p_in;
      c1_ff    <= req_col_index;
      hs1_ff   <= hs_in;
      off1_ff  <= req_row_index[1:0] - p_in[1:0];
      cols1_ff <= cols_ff;
   end

   // stage 2: panel base times row length, column offset
   logic                 oor2_ff;
   logic [DestWidth-1:0] prod2_ff, coff2_ff;

   always_ff @(posedge clock) begin
      oor2_ff  <= oor1_ff;
      prod2_ff <= {12'd0, p1_ff} * {11'd0, cols1_ff};
      coff2_ff <= DestWidth'(({2'b00, c1_ff} << hs1_ff) + {12'd0, off1_ff});
   end

   // stage 3: final sum, forced to zero for an out-of-range beat
   logic                 oor3_ff;
   logic [DestWidth-1:0] dest3_ff;

   always_ff @(posedge clock) begin
      oor3_ff  <= oor2_ff;
      dest3_ff <= oor2_ff ? '0 : prod2_ff + coff2_ff;
   end

   assign rsp_valid        = vld_ff[2];
   assign rsp_dest_index   = dest3_ff;
   assign rsp_out_of_range = oor3_ff;

`ifndef SYNTHESIS
   a_lat : assert property (@(posedge clock) disable iff (reset)
      acc |-> ##3 rsp_valid) else $error("response beat missing");
   a_oor : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_dest_index == '0)
      else $error("flagged beat has nonzero index");
   a_cfg : assert property (@(posedge clock) disable iff (reset)
      rows_ff <= CfgWidth'(MaxDim) && cols_ff <= CfgWidth'(MaxDim))
      else $error("size register above max");
`endif

endmodule
